[rtl/core/lzssd_pkg.sv]
// Shared constants and types for the LZSS decompressor.
package lzssd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = WIN_AW + 1;

  localparam logic [WIN_AW-1:0] WRITE_START = 12'hFEE;
  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(WIN_DEPTH);

  localparam logic [3:0] CODES_PER_FLAG = 4'd8;
  localparam logic [4:0] MATCH_MIN      = 5'd3;

  // Window access for one cycle: one write port, one read port.
  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
    logic              clear;
  } win_req_t;

endpackage

[rtl/core/lzssd_window.sv]
// History window: 4K byte RAM, fill count for per-block clearing, write-to-read forwarding.
module lzssd_window (
  input  logic                clk,
  input  logic                rst_n,
  input  lzssd_pkg::win_req_t req,
  output logic [7:0]          rd_byte
);

  logic [7:0] mem [lzssd_pkg::WIN_DEPTH];
  logic [7:0] rdata_r;

  logic [lzssd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                         vld_r, vld_nxt;
  logic                         fwd_r, fwd_nxt;
  logic [7:0]                   fwd_data_r;
  logic [lzssd_pkg::WIN_AW-1:0] rd_off;

  // Writes run sequentially from the start position, so an entry holds data
  // from this block iff its distance from the start is below the fill count.
  assign rd_off = req.raddr - lzssd_pkg::WRITE_START;

  always_comb begin
    fill_nxt = fill_r;
    if (req.clear) begin
      fill_nxt = '0;
    end else if (req.we && fill_r != lzssd_pkg::FILL_FULL) begin
      fill_nxt = fill_r + 1'b1;
    end
    vld_nxt = vld_r;
    fwd_nxt = fwd_r;
    if (req.re) begin
      vld_nxt = {1'b0, rd_off} < fill_r;
      fwd_nxt = req.we && (req.raddr == req.waddr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r    <= mem[req.raddr];
      fwd_data_r <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      vld_r  <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      vld_r  <= vld_nxt;
      fwd_r  <= fwd_nxt;
    end
  end

  assign rd_byte = fwd_r ? fwd_data_r : (vld_r ? rdata_r : 8'h00);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lzssd_pkg::FILL_FULL)
    else $error("window fill count beyond depth");

endmodule

[rtl/core/lzss_decompressor.sv]
// LZSS decompressor top level: code parser, match copy sequencer, output register.
// Flag bytes and first match bytes give no result.
// A literal is loaded into the output register on its input transfer.
// A match reads its first byte from the window RAM once its second byte is taken, then
// gives one byte per cycle from the RAM read port while the output is not stalled.
// Synchronous active-low reset; no RAM sweep, a fill count reads unwritten entries as zero.
module lzss_decompressor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_block
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic                         state_r, state_nxt;
  logic [lzssd_pkg::WIN_AW-1:0] wp_r, wp_nxt;
  logic [lzssd_pkg::WIN_AW-1:0] rd_r, rd_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         eob_r, eob_nxt;
  logic [7:0]                   flag_r, flag_nxt;
  logic [3:0]                   codes_r, codes_nxt;
  logic                         await_r, await_nxt;
  logic [7:0]                   low_r, low_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic                         slot_free, in_fire, copy_go;
  logic [lzssd_pkg::WIN_AW-1:0] match_addr;
  logic [7:0]                   win_byte;
  lzssd_pkg::win_req_t          req;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && slot_free;
  assign in_fire    = in_tvalid && in_tready;
  assign copy_go    = (state_r == ST_COPY) && slot_free;
  assign match_addr = {in_tdata[7:4], low_r};

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    eob_nxt       = eob_r;
    flag_nxt      = flag_r;
    codes_nxt     = codes_r;
    await_nxt     = await_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    req           = '0;

    if (in_fire) begin
      if (codes_r == 4'd0) begin
        flag_nxt  = in_tdata;
        codes_nxt = lzssd_pkg::CODES_PER_FLAG;
      end else if (flag_r[0]) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = in_tdata;
        out_last_nxt  = 1'b1;
        req.we        = 1'b1;
        req.waddr     = wp_r;
        req.wdata     = in_tdata;
        wp_nxt        = wp_r + 1'b1;
        flag_nxt      = {1'b0, flag_r[7:1]};
        codes_nxt     = codes_r - 1'b1;
      end else if (!await_r) begin
        low_nxt   = in_tdata;
        await_nxt = 1'b1;
      end else begin
        await_nxt = 1'b0;
        flag_nxt  = {1'b0, flag_r[7:1]};
        codes_nxt = codes_r - 1'b1;
        req.re    = 1'b1;
        req.raddr = match_addr;
        rd_nxt    = match_addr + 1'b1;
        cnt_nxt   = {1'b0, in_tdata[3:0]} + lzssd_pkg::MATCH_MIN;
        eob_nxt   = in_tlast;
        state_nxt = ST_COPY;
      end
      if (in_tlast) begin
        flag_nxt  = '0;
        codes_nxt = '0;
        await_nxt = 1'b0;
        low_nxt   = '0;
        // a match still has its copy to run; the window resets when it ends
        if (state_nxt == ST_IDLE) begin
          wp_nxt    = lzssd_pkg::WRITE_START;
          req.clear = 1'b1;
        end
      end
    end

    if (copy_go) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = win_byte;
      out_last_nxt  = (cnt_r == 5'd1);
      req.we        = 1'b1;
      req.waddr     = wp_r;
      req.wdata     = win_byte;
      wp_nxt        = wp_r + 1'b1;
      cnt_nxt       = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        state_nxt = ST_IDLE;
        if (eob_r) begin
          wp_nxt    = lzssd_pkg::WRITE_START;
          req.clear = 1'b1;
        end
      end else begin
        // overlapping copy: a read of the entry written now is forwarded
        req.re    = 1'b1;
        req.raddr = rd_r;
        rd_nxt    = rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= lzssd_pkg::WRITE_START;
      cnt_r       <= '0;
      eob_r       <= 1'b0;
      flag_r      <= '0;
      codes_r     <= '0;
      await_r     <= 1'b0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      eob_r       <= eob_nxt;
      flag_r      <= flag_nxt;
      codes_r     <= codes_nxt;
      await_r     <= await_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  lzssd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_byte (win_byte)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_copy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY |-> cnt_r != 5'd0)
    else $error("copy running with zero count");

  a_codes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    codes_r <= lzssd_pkg::CODES_PER_FLAG)
    else $error("code count beyond flag width");

  a_await_codes: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> codes_r != 4'd0)
    else $error("pending match outside a flag group");

  a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (copy_go && cnt_r == 5'd1 && eob_r) |=> wp_r == lzssd_pkg::WRITE_START)
    else $error("write position not restored after block end");

  a_copy_last: assert property (@(posedge clk) disable iff (!rst_n)
    (copy_go && cnt_r != 5'd1) |=> (out_tvalid && !out_tlast))
    else $error("copy byte flagged as last too early");

endmodule
